### src/fcull_pkg.sv
// Shared types and constants for the frustum point cull block.
package fcull_pkg;

   // Width of one normal component, signed Q1.15.
   localparam int unsigned NORMAL_W = 16;
   // Packed normal: x in [15:0], y in [31:16], z in [47:32].
   localparam int unsigned NORMALS_W = 3 * NORMAL_W;
   // The limit is (offset - cutoff) scaled by 2^15 to line up with Q.15 dot products.
   localparam int unsigned FRAC_SHIFT = 15;

   // Request function codes.
   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_TEST  = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } state_type;

   // Sequencer to datapath.
   typedef struct packed {
      logic start;     // new test request, clear the fail flag
      logic rd_valid;  // plane read data valid this cycle
   } ctl_type;

   // Datapath to sequencer.
   typedef struct packed {
      logic busy;      // a plane compare is still in flight
      logic fail;      // some tested plane rejected the point
   } stat_type;

endpackage

### src/fcull_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module fcull_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 8
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/fcull_dot.sv
// Plane test datapath: multiply stage, then sum-and-compare stage with a sticky fail flag.
module fcull_dot #(
   parameter int unsigned COORD_BITS = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  fcull_pkg::ctl_type                   ctl,
   input  logic [fcull_pkg::NORMALS_W-1:0]      normal_data,
   input  logic [COORD_BITS-1:0]                offset_data,
   input  logic signed [COORD_BITS-1:0]         point_x,
   input  logic signed [COORD_BITS-1:0]         point_y,
   input  logic signed [COORD_BITS-1:0]         point_z,
   input  logic signed [COORD_BITS-1:0]         cutoff,
   output fcull_pkg::stat_type                  stat
);

   localparam int unsigned PROD_W = fcull_pkg::NORMAL_W + COORD_BITS;
   localparam int unsigned SUM_W  = PROD_W + 2;
   localparam int unsigned DIFF_W = COORD_BITS + 1;
   localparam int unsigned LIM_W  = DIFF_W + fcull_pkg::FRAC_SHIFT;

   logic signed [fcull_pkg::NORMAL_W-1:0] nx, ny, nz;
   logic signed [PROD_W-1:0] prod_x_ff, prod_y_ff, prod_z_ff;
   logic signed [PROD_W-1:0] prod_x_in, prod_y_in, prod_z_in;
   logic signed [DIFF_W-1:0] diff_ff, diff_in;
   logic signed [SUM_W-1:0]  dot_sum;
   logic signed [LIM_W-1:0]  limit;
   logic                     v2_ff, v2_in;
   logic                     fail_ff, fail_in;

   assign nx = $signed(normal_data[fcull_pkg::NORMAL_W-1:0]);
   assign ny = $signed(normal_data[2*fcull_pkg::NORMAL_W-1:fcull_pkg::NORMAL_W]);
   assign nz = $signed(normal_data[3*fcull_pkg::NORMAL_W-1:2*fcull_pkg::NORMAL_W]);

   // Multiply stage.
   assign prod_x_in = PROD_W'(nx) * PROD_W'(point_x);
   assign prod_y_in = PROD_W'(ny) * PROD_W'(point_y);
   assign prod_z_in = PROD_W'(nz) * PROD_W'(point_z);
   assign diff_in   = DIFF_W'($signed(offset_data)) - DIFF_W'(cutoff);
   assign v2_in     = ctl.rd_valid && !ctl.start;

   // Compare stage.
   assign dot_sum = SUM_W'(prod_x_ff) + SUM_W'(prod_y_ff) + SUM_W'(prod_z_ff);
   assign limit   = LIM_W'(diff_ff) <<< fcull_pkg::FRAC_SHIFT;

   always_comb begin
      fail_in = fail_ff;
      if (ctl.start) begin
         fail_in = 1'b0;
      end else if (v2_ff && (dot_sum < SUM_W'(limit))) begin
         fail_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff   <= 1'b0;
         fail_ff <= 1'b0;
      end else begin
         v2_ff   <= v2_in;
         fail_ff <= fail_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_x_ff <= prod_x_in;
      prod_y_ff <= prod_y_in;
      prod_z_ff <= prod_z_in;
      diff_ff   <= diff_in;
   end

   assign stat.busy = v2_ff;
   assign stat.fail = fail_ff;

endmodule

### src/frustum_point_cull.sv
// Top level of the frustum point cull block: plane store, sequencer and result register.
//
// Planes live in two small RAMs (normals and offsets, MAX_PLANES entries each).
// A write request (func = write) stores one plane and gives no response; a slot
// at or above MAX_PLANES is dropped. A test request takes the point and cutoff,
// then walks the first min(active_planes, MAX_PLANES) slots, one RAM read per
// cycle; each plane passes through a multiply stage and a sum-and-compare stage.
// A test holds req_stall from acceptance until its verdict is loaded into the
// output register, the reads being serialized by the single RAM read port; the
// verdict also waits while a stalled response still occupies the output register;
// with no active planes the point comes back visible.
// Results wait in an output register, so the next request is accepted while a
// response is still stalled. active_planes is written through the csr channel,
// which is always ready and must only be written while no request is in flight.
// Plane slots never written since reset give undefined results when tested.
module frustum_point_cull #(
   parameter int unsigned MAX_PLANES = 8,
   parameter int unsigned COORD_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_func,
   input  logic [2:0]            req_plane_index,
   input  logic [15:0]           req_normal_x,
   input  logic [15:0]           req_normal_y,
   input  logic [15:0]           req_normal_z,
   input  logic [COORD_BITS-1:0] req_plane_offset,
   input  logic [COORD_BITS-1:0] req_point_x,
   input  logic [COORD_BITS-1:0] req_point_y,
   input  logic [COORD_BITS-1:0] req_point_z,
   input  logic [COORD_BITS-1:0] req_cutoff,
   // response channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_visible,
   // register write channel
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [3:0]            csr_active_planes
);

   localparam int unsigned IDX_W = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;
   localparam int unsigned CNT_W = $clog2(MAX_PLANES + 1);

   fcull_pkg::state_type state_ff, state_in;
   fcull_pkg::ctl_type   ctl;
   fcull_pkg::stat_type  stat;

   logic [3:0]       active_ff, active_in;
   logic [CNT_W-1:0] count_ff, count_in;     // planes to test
   logic [CNT_W-1:0] issue_ff, issue_in;     // planes read so far
   logic             v1_ff, v1_in;           // RAM read data valid
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_visible_ff, rsp_visible_in;

   logic signed [COORD_BITS-1:0] px_ff, py_ff, pz_ff, cut_ff;

   logic             accept, test_accept, wr_en, rd_en, done, out_free;
   logic [4:0]       slot_ext;
   logic [IDX_W-1:0] wr_addr;
   logic [CNT_W-1:0] count_sat;
   logic [fcull_pkg::NORMALS_W-1:0] normal_rd;
   logic [COORD_BITS-1:0]           offset_rd;

   assign csr_ready = 1'b1;

   assign accept      = req_valid && !req_stall;
   assign test_accept = accept && (req_func == fcull_pkg::FUNC_TEST);

   // Drop writes to slots beyond the store.
   assign slot_ext = 5'(req_plane_index);
   assign wr_addr  = slot_ext[IDX_W-1:0];
   assign wr_en    = accept && (req_func == fcull_pkg::FUNC_WRITE) &&
                     (slot_ext < 5'(MAX_PLANES));

   // Clamp the plane count to the store depth.
   assign count_sat = ({1'b0, active_ff} > 5'(MAX_PLANES)) ? CNT_W'(MAX_PLANES)
                                                           : CNT_W'(active_ff);

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign done     = (issue_ff == count_ff) && !v1_ff && !stat.busy;

   always_comb begin
      state_in       = state_ff;
      req_stall      = 1'b1;
      rd_en          = 1'b0;
      count_in       = count_ff;
      issue_in       = issue_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_visible_in = rsp_visible_ff;
      active_in      = (csr_valid && csr_ready) ? csr_active_planes : active_ff;
      case (state_ff)
         fcull_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (test_accept) begin
               count_in = count_sat;
               issue_in = '0;
               state_in = fcull_pkg::ST_SCAN;
            end
         end
         fcull_pkg::ST_SCAN: begin
            // Issue one plane read per cycle until all are out.
            if (issue_ff < count_ff) begin
               rd_en    = 1'b1;
               issue_in = issue_ff + CNT_W'(1);
            end
            // Hold the verdict until the output register frees up.
            if (done && out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_visible_in = !stat.fail;
               state_in       = fcull_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fcull_pkg::ST_IDLE;
         end
      endcase
   end

   assign v1_in        = rd_en;
   assign ctl.start    = test_accept;
   assign ctl.rd_valid = v1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fcull_pkg::ST_IDLE;
         active_ff    <= '0;
         count_ff     <= '0;
         issue_ff     <= '0;
         v1_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         count_ff     <= count_in;
         issue_ff     <= issue_in;
         v1_ff        <= v1_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Capture the point on test acceptance.
   always_ff @(posedge clock) begin
      rsp_visible_ff <= rsp_visible_in;
      if (test_accept) begin
         px_ff  <= $signed(req_point_x);
         py_ff  <= $signed(req_point_y);
         pz_ff  <= $signed(req_point_z);
         cut_ff <= $signed(req_cutoff);
      end
   end

   fcull_ram #(
      .WIDTH (fcull_pkg::NORMALS_W),
      .DEPTH (MAX_PLANES)
   ) u_normal_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data ({req_normal_z, req_normal_y, req_normal_x}),
      .rd_en   (rd_en),
      .rd_addr (issue_ff[IDX_W-1:0]),
      .rd_data (normal_rd)
   );

   fcull_ram #(
      .WIDTH (COORD_BITS),
      .DEPTH (MAX_PLANES)
   ) u_offset_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_plane_offset),
      .rd_en   (rd_en),
      .rd_addr (issue_ff[IDX_W-1:0]),
      .rd_data (offset_rd)
   );

   fcull_dot #(
      .COORD_BITS (COORD_BITS)
   ) u_dot (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .normal_data (normal_rd),
      .offset_data (offset_rd),
      .point_x     (px_ff),
      .point_y     (py_ff),
      .point_z     (pz_ff),
      .cutoff      (cut_ff),
      .stat        (stat)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_visible = rsp_visible_ff;

endmodule

### src/fcull_chk.sv
// Port-level checker for the frustum point cull block, with its bind.
module fcull_chk (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic req_func,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic rsp_visible
);

   // A stalled response holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_visible))
      else $error("stalled response changed");

   // No response survives reset.
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A plane write never produces a response.
   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_func == fcull_pkg::FUNC_WRITE) && !rsp_valid
      |=> !rsp_valid)
      else $error("plane write produced a response");

   // A test request blocks the request channel while it runs.
   a_test_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_func == fcull_pkg::FUNC_TEST) |=> req_stall)
      else $error("request accepted during a test");

endmodule

bind frustum_point_cull fcull_chk u_fcull_chk (.*);
